FILE: sv/pps_pkg.sv
// shared constants and types for the preemptive priority scheduler
// no dependencies; imported by every module of the block
package pps_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TICK_W      = 24;
  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int PCOUNT_W    = 5;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // action codes of an input beat
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] original;
    logic [TICK_W-1:0]  arrival;
    logic [PRIO_W-1:0]  prio;
    logic [TICK_W-1:0]  waiting;
  } entry_t;

endpackage

FILE: sv/pps_table.sv
// process table: one synchronous memory, one read and one write port
// per-entry valid bits make unwritten entries read as zero; uses pps_pkg
module pps_table
  import pps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   rd_en,
  input  idx_t   rd_addr,
  output entry_t rd_data,
  input  logic   wr_en,
  input  idx_t   wr_addr,
  input  entry_t wr_data
);

  entry_t                 mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld;
  entry_t                 q;
  logic                   q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

FILE: sv/preemptive_priority_scheduler_top.sv
// top level of the preemptive priority scheduler: control sequencer and ports
// depends on pps_pkg and pps_table
//
// A load beat writes one entry of the process table (burst, arrival tick,
// priority, waiting count cleared) and passes through ST_OUT to the output
// register. A tick beat scans the first process_count entries twice over
// the table's single read port: the first pass finds the arrived, unfinished
// entry with the smallest priority number (lowest index on ties), the second
// pass reads each entry again and writes it back, decrementing the served
// entry's remaining burst and adding one, saturating, to the waiting count of
// every other eligible entry. The scan covers process_count clipped to the
// table depth of 16. A tick that finds no eligible entry, or no entry in
// use, skips the second pass. One beat is in work at a time, and the next
// beat is taken as soon as its result sits in the output register, even
// while that result is still stalled. Completion reports the waiting count
// and waiting plus original burst, both saturating at 2^24-1.
// process_count may only be written while the block is idle; the config
// channel is always ready.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PCOUNT_W-1:0] cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic [BURST_W-1:0]  burst_length,
  input  logic [TICK_W-1:0]   arrival_time,
  input  logic [PRIO_W-1:0]   priority_level,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [IDX_W-1:0]    selected_entry,
  output logic                idle,
  output logic                finished,
  output logic [TICK_W-1:0]   finished_waiting,
  output logic [TICK_W-1:0]   finished_turnaround,
  output logic                all_done
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIND = 2'd1;  // first pass, pick the winner
  localparam logic [1:0] ST_UPD  = 2'd2;  // second pass, read-modify-write
  localparam logic [1:0] ST_OUT  = 2'd3;  // hand result to output register

  logic [1:0]             state;
  logic [PCOUNT_W-1:0]    process_count;
  logic [TICK_W-1:0]      tick;
  logic [MAX_ENTRIES-1:0] busy;          // entry still has remaining burst
  cnt_t                   cnt;           // read address issue counter
  logic                   rd_act;        // read data returns this cycle
  idx_t                   rd_idx;
  logic                   found;
  idx_t                   best_idx;
  logic [PRIO_W-1:0]      best_prio;

  // result held until the output register is free
  idx_t                   res_sel;
  logic                   res_idle;
  logic                   res_fin;
  logic [TICK_W-1:0]      res_wait;
  logic [TICK_W-1:0]      res_turn;

  cnt_t                   n_use;
  logic                   in_acc;
  logic                   out_free;
  logic                   rd_en;
  idx_t                   rd_addr;
  entry_t                 rd_data;
  logic                   wr_en;
  idx_t                   wr_addr;
  entry_t                 wr_data;
  logic                   elig;
  logic                   pass_end;
  logic                   none_left;
  logic [BURST_W-1:0]     rem_dec;
  logic [TICK_W:0]        turn_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // entries in use, clipped to the table depth
  assign n_use = (32'(process_count) > MAX_ENTRIES) ? cnt_t'(MAX_ENTRIES)
                                                    : cnt_t'(process_count);

  // read issue for both passes
  assign rd_en    = ((state == ST_FIND) || (state == ST_UPD)) && (cnt < n_use);
  assign rd_addr  = cnt[IDX_W-1:0];
  assign pass_end = (cnt == n_use) && !rd_act;

  // eligibility uses the tick before this beat advances it
  assign elig     = (rd_data.remaining != '0) && (tick >= rd_data.arrival);
  assign rem_dec  = rd_data.remaining - BURST_W'(1);
  assign turn_sum = {1'b0, rd_data.waiting} + (TICK_W+1)'(rd_data.original);

  pps_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // write port: a load beat, or the write-back half of the second pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    if (in_acc && (action == ACT_LOAD)) begin
      wr_en   = 1'b1;
      wr_addr = entry_index;
      wr_data = '{remaining: burst_length, original: burst_length,
                  arrival: arrival_time, prio: priority_level, waiting: '0};
    end else if ((state == ST_UPD) && rd_act) begin
      if (found && (rd_idx == best_idx)) begin
        wr_en             = 1'b1;
        wr_data.remaining = rem_dec;
      end else if (elig) begin
        wr_en = 1'b1;
        if (rd_data.waiting != TICK_MAX) begin
          wr_data.waiting = rd_data.waiting + TICK_W'(1);
        end
      end
    end
  end

  // any entry in use with burst left
  always_comb begin
    none_left = 1'b1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (busy[i] && (cnt_t'(i) < n_use)) begin
        none_left = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      process_count <= '0;
      tick          <= '0;
      busy          <= '0;
      cnt           <= '0;
      rd_act        <= 1'b0;
      rd_idx        <= '0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        process_count <= cfg_data;
      end

      rd_act <= rd_en;
      rd_idx <= rd_addr;
      if (rd_en) begin
        cnt <= cnt + cnt_t'(1);
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            res_sel  <= '0;
            res_idle <= 1'b0;
            res_fin  <= 1'b0;
            res_wait <= '0;
            res_turn <= '0;
            cnt      <= '0;
            found    <= 1'b0;
            if (action == ACT_LOAD) begin
              busy[entry_index] <= (burst_length != '0);
              state             <= ST_OUT;
            end else begin
              state <= ST_FIND;
            end
          end
        end
        ST_FIND: begin
          if (rd_act && elig && (!found || (rd_data.prio < best_prio))) begin
            found     <= 1'b1;
            best_idx  <= rd_idx;
            best_prio <= rd_data.prio;
          end
          if (pass_end) begin
            cnt <= '0;
            if (found) begin
              state <= ST_UPD;
            end else begin
              res_idle <= 1'b1;
              if (tick != TICK_MAX) begin
                tick <= tick + TICK_W'(1);
              end
              state <= ST_OUT;
            end
          end
        end
        ST_UPD: begin
          if (rd_act && (rd_idx == best_idx) && (rem_dec == '0)) begin
            busy[rd_idx] <= 1'b0;
            res_fin      <= 1'b1;
            res_wait     <= rd_data.waiting;
            res_turn     <= turn_sum[TICK_W] ? TICK_MAX : turn_sum[TICK_W-1:0];
          end
          if (pass_end) begin
            res_sel <= best_idx;
            if (tick != TICK_MAX) begin
              tick <= tick + TICK_W'(1);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            selected_entry      <= res_sel;
            idle                <= res_idle;
            finished            <= res_fin;
            finished_waiting    <= res_wait;
            finished_turnaround <= res_turn;
            all_done            <= none_left;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/pps_checker.sv
// port-level checker for the preemptive priority scheduler, bound to the top
// depends on pps_pkg and preemptive_priority_scheduler_top
module pps_checker
  import pps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [IDX_W-1:0]    selected_entry,
  input logic                idle,
  input logic                finished,
  input logic [TICK_W-1:0]   finished_waiting,
  input logic [TICK_W-1:0]   finished_turnaround
);

  // one beat in work at a time: an accepted input beat stalls the next
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a beat is in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(selected_entry) &&
      $stable(finished) && $stable(finished_turnaround))
    else $error("stalled result beat changed");

  // an idle tick serves nothing
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> !finished && (selected_entry == '0))
    else $error("idle tick reports a served entry");

  // turnaround never below waiting
  a_turn_ge_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> finished_turnaround >= finished_waiting)
    else $error("turnaround below waiting");

  // no completion figures without a completion
  a_no_fin_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished |-> (finished_waiting == '0) &&
      (finished_turnaround == '0))
    else $error("completion figures without completion");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .selected_entry      (selected_entry),
  .idle                (idle),
  .finished            (finished),
  .finished_waiting    (finished_waiting),
  .finished_turnaround (finished_turnaround)
);
